// File: rtl/epoch_seconds_to_calendar_unit_defines.svh
// Assertion helpers shared by the calendar converter.
`ifndef EPOCH_SECONDS_TO_CALENDAR_UNIT_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ESC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/esc_pkg.sv
`timescale 1ns / 1ps

package esc_pkg;

    // Pipeline stage positions
    localparam int ST_LOCAL    = 0;
    localparam int ST_QEST     = 1;
    localparam int ST_REST     = 2;
    localparam int ST_DAYS     = 3;
    localparam int ST_DOE      = 4;
    localparam int ST_CENT     = 5;
    localparam int ST_NORM     = 6;
    localparam int ST_YOE      = 7;
    localparam int ST_DOY      = 8;
    localparam int ST_MP       = 9;
    localparam int ST_OUT      = 10;
    localparam int STAGE_COUNT = 11;

    // Time constants
    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int MINS_PER_HOUR = 60;
    localparam int DAYS_PER_YEAR = 365;
    localparam int EPOCH_YEAR    = 1970;

    // Calendar constants (days counted from 0000-03-01)
    localparam int DAYS_TO_EPOCH  = 719468;
    localparam int DAYS_PER_ERA   = 146097;
    localparam int DAYS_PER_4Y    = 1460;
    localparam int DAYS_PER_100Y  = 36524;
    localparam int DAYS_ERA_LAST  = 146096;
    localparam int YEARS_PER_ERA  = 400;
    localparam int ERA_LO         = DAYS_TO_EPOCH / DAYS_PER_ERA;
    localparam int ERA_SPLIT      = (ERA_LO + 1) * DAYS_PER_ERA;

    // Widths
    localparam int SECS_W   = 32;
    localparam int LOCAL_W  = 33;
    localparam int OFFS_W   = 18;
    localparam int DAYS_W   = 16;
    localparam int REM_W    = 17;
    localparam int DOE_W    = 18;
    localparam int YOE_W    = 9;
    localparam int DOY_W    = 9;
    localparam int MOD_W    = 11;

    // Reciprocal constants
    // 86400 = 128 * 675; floor reciprocal, estimate is low by at most one
    localparam int  DAY_PRESHIFT = 7;
    localparam int  DIV675_SHIFT = 36;
    localparam logic [26:0] DIV675_MULT = 27'((64'd1 << DIV675_SHIFT) / 675);
    // ceil reciprocals, exact over the operand range
    localparam int  DIV15_SHIFT = 19;
    localparam logic [15:0] DIV15_MULT = 16'(((64'd1 << DIV15_SHIFT) + 14) / 15);
    localparam int  DIV1460_SHIFT = 29;
    localparam logic [18:0] DIV1460_MULT =
        19'(((64'd1 << DIV1460_SHIFT) + DAYS_PER_4Y - 1) / DAYS_PER_4Y);
    localparam int  DIV365_SHIFT = 27;
    localparam logic [18:0] DIV365_MULT =
        19'(((64'd1 << DIV365_SHIFT) + DAYS_PER_YEAR - 1) / DAYS_PER_YEAR);

    localparam logic signed [4:0] ZONE_OFFSET_RESET = 5'sd8;

    typedef logic [STAGE_COUNT-1:0] stage_en_t;

    // Zone offset in seconds
    function automatic logic signed [OFFS_W-1:0] zone_secs(input logic signed [4:0] hrs);
        logic signed [OFFS_W-1:0] ext;
        logic signed [OFFS_W-1:0] scale;
        ext   = $signed({{(OFFS_W-5){hrs[4]}}, hrs});
        scale = OFFS_W'(SECS_PER_HOUR);
        return ext * scale;
    endfunction

    // First day of each month within a March-based year
    function automatic logic [DOY_W-1:0] month_start(input logic [3:0] mp);
        logic [DOY_W-1:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/epoch_seconds_to_calendar_unit.sv
// Throughput: one item per cycle unless the result side stalls; the eleven-stage
// pipeline holds up to eleven items.
// A stall on the result side holds only full stages; bubbles still fill behind it.
// Reset (rst_n, async, active low) empties the pipeline and sets the zone offset to +8 h.
`timescale 1ns / 1ps
`include "epoch_seconds_to_calendar_unit_defines.svh"

module epoch_seconds_to_calendar_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    // Zone offset write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic signed [4:0]         zone_offset_hours,
    // Input item channel
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic [31:0]               epoch_seconds,
    // Result item channel
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [11:0]               year,
    output logic [3:0]                month,
    output logic [4:0]                day_of_month,
    output logic [4:0]                hour,
    output logic [5:0]                minute
);

    // Stage map:
    //   0      add zone offset in seconds, clamp before the epoch to zero
    //   1..3   split seconds into days and seconds of day
    //          (reciprocal estimate, remainder, one-step correction)
    //   4..10  days go through the era/year-of-era/day-of-year calendar math
    //          while seconds of day become hour and minute in parallel
    // Every stage has its own load enable from the control block, so an item
    // moves up whenever the stage ahead of it is empty or moving.

    logic signed [esc_pkg::OFFS_W-1:0] offset_secs_reg;
    logic signed [esc_pkg::OFFS_W-1:0] offset_secs_next;

    esc_pkg::stage_en_t              stage_en;
    logic [esc_pkg::DAYS_W-1:0]      days;
    logic [esc_pkg::REM_W-1:0]       rem;

    // Always take configuration; the offset is kept pre-scaled to seconds
    // so the first stage needs only an add.
    assign cfg_ready        = 1'b1;
    assign offset_secs_next = esc_pkg::zone_secs(zone_offset_hours);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_secs_reg <= esc_pkg::zone_secs(esc_pkg::ZONE_OFFSET_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            offset_secs_reg <= offset_secs_next;
        end
    end

    // Valid bits and per-stage load enables
    esc_pipe_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stage_en     (stage_en)
    );

    // Local seconds to whole days plus seconds of day
    esc_day_split u_day_split (
        .clk           (clk),
        .stage_en      (stage_en),
        .epoch_seconds (epoch_seconds),
        .offset_secs   (offset_secs_reg),
        .days          (days),
        .rem           (rem)
    );

    // Days since epoch to Gregorian date
    esc_civil u_civil (
        .clk          (clk),
        .stage_en     (stage_en),
        .days         (days),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month)
    );

    // Seconds of day to hour and minute, delayed to line up with the date
    esc_tod u_tod (
        .clk      (clk),
        .stage_en (stage_en),
        .rem      (rem),
        .hour     (hour),
        .minute   (minute)
    );

    `ESC_ASSERT_IMPLY(a_result_fields_in_range, clk, rst_n, result_valid, month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1 && hour <= 5'd23 && minute <= 6'd59, "result field out of calendar range")
    `ESC_ASSERT_IMPLY(a_result_year_in_range, clk, rst_n, result_valid, year >= 12'd1970 && year <= 12'd2106, "result year out of range")
    `ESC_ASSERT_NEXT(a_offset_follows_write, clk, rst_n, cfg_valid && cfg_ready, offset_secs_reg == esc_pkg::zone_secs($past(zone_offset_hours)), "zone offset write not taken")

endmodule

// File: rtl/esc_pipe_ctrl.sv
`timescale 1ns / 1ps
`include "epoch_seconds_to_calendar_unit_defines.svh"

module esc_pipe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    output logic              result_valid,
    input  logic              result_stall,
    output esc_pkg::stage_en_t stage_en
);

    localparam int N = esc_pkg::STAGE_COUNT;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N-1:0] advance;

    // A stage loads when it is empty or its successor moves on
    always_comb
    begin
        advance[N-1] = !valid_reg[N-1] || !result_stall;
        for (int s = N - 2; s >= 0; s--)
        begin
            advance[s] = !valid_reg[s] || advance[s+1];
        end
    end

    assign valid_next   = (advance & {valid_reg[N-2:0], item_valid}) | (~advance & valid_reg);
    assign stage_en     = advance;
    assign item_stall   = !advance[0];
    assign result_valid = valid_reg[N-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    `ESC_ASSERT_NEXT(a_accept_fills_first, clk, rst_n, item_valid && !item_stall, valid_reg[0], "accepted item did not enter first stage")
    `ESC_ASSERT_IMPLY(a_stall_only_when_full, clk, rst_n, item_stall, &valid_reg, "input stalled while a bubble exists")
    `ESC_ASSERT_NEXT(a_held_result_stays, clk, rst_n, (&valid_reg) && result_stall, $stable(valid_reg), "pipeline moved during output stall with full stages")

endmodule

// File: rtl/esc_day_split.sv
`timescale 1ns / 1ps

module esc_day_split (
    input  logic                                  clk,
    input  esc_pkg::stage_en_t                    stage_en,
    input  logic [esc_pkg::SECS_W-1:0]            epoch_seconds,
    input  logic signed [esc_pkg::OFFS_W-1:0]     offset_secs,
    output logic [esc_pkg::DAYS_W-1:0]            days,
    output logic [esc_pkg::REM_W-1:0]             rem
);

    localparam int LW = esc_pkg::LOCAL_W;
    localparam int DW = esc_pkg::DAYS_W;
    localparam int RW = esc_pkg::REM_W;
    localparam int XW = LW - esc_pkg::DAY_PRESHIFT;
    localparam int PW = XW + 27;

    logic [LW-1:0]   local_reg, local_next, local1_reg;
    logic [DW-1:0]   qest_reg, qest_next, q2_reg;
    logic [RW:0]     rest_reg, rest_next;
    logic [DW-1:0]   days_reg, days_next;
    logic [RW-1:0]   rem_reg, rem_next;

    logic signed [LW:0] sum;
    logic [XW-1:0]      scaled;
    logic [PW-1:0]      prod, prod_sh;
    logic [LW-1:0]      day_base, diff;

    // Add the zone offset, clamp below the epoch
    always_comb
    begin
        sum = $signed({2'b00, epoch_seconds}) + $signed({{(LW+1-esc_pkg::OFFS_W){offset_secs[esc_pkg::OFFS_W-1]}}, offset_secs});
        local_next = sum[LW] ? '0 : sum[LW-1:0];
    end

    // Estimate days by reciprocal
    always_comb
    begin
        scaled    = local_reg[LW-1:esc_pkg::DAY_PRESHIFT];
        prod      = PW'(scaled) * PW'(esc_pkg::DIV675_MULT);
        prod_sh   = prod >> esc_pkg::DIV675_SHIFT;
        qest_next = prod_sh[DW-1:0];
    end

    // Remainder of the estimate, below two days
    always_comb
    begin
        day_base  = LW'(qest_reg) * LW'(esc_pkg::SECS_PER_DAY);
        diff      = local1_reg - day_base;
        rest_next = diff[RW:0];
    end

    // Correct the estimate
    always_comb
    begin
        if (rest_reg >= (RW+1)'(esc_pkg::SECS_PER_DAY))
        begin
            days_next = q2_reg + DW'(1);
            rem_next  = RW'(rest_reg - (RW+1)'(esc_pkg::SECS_PER_DAY));
        end
        else
        begin
            days_next = q2_reg;
            rem_next  = rest_reg[RW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[esc_pkg::ST_LOCAL])
        begin
            local_reg <= local_next;
        end
        if (stage_en[esc_pkg::ST_QEST])
        begin
            qest_reg   <= qest_next;
            local1_reg <= local_reg;
        end
        if (stage_en[esc_pkg::ST_REST])
        begin
            rest_reg <= rest_next;
            q2_reg   <= qest_reg;
        end
        if (stage_en[esc_pkg::ST_DAYS])
        begin
            days_reg <= days_next;
            rem_reg  <= rem_next;
        end
    end

    assign days = days_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/esc_civil.sv
`timescale 1ns / 1ps

module esc_civil (
    input  logic                        clk,
    input  esc_pkg::stage_en_t          stage_en,
    input  logic [esc_pkg::DAYS_W-1:0]  days,
    output logic [11:0]                 year,
    output logic [3:0]                  month,
    output logic [4:0]                  day_of_month
);

    localparam int EW = esc_pkg::DOE_W;
    localparam int YW = esc_pkg::YOE_W;
    localparam int DY = esc_pkg::DOY_W;
    localparam int ZW = 20;
    localparam int PW = EW + 19;

    // Day of era stage
    logic [EW-1:0] doe4_reg, doe4_next;
    logic          era4_reg, era4_next;
    // Century term stage
    logic [6:0]    a_reg, a_next;
    logic [2:0]    b_reg, b_next;
    logic          c_reg, c_next;
    logic [EW-1:0] doe5_reg;
    logic          era5_reg;
    // Normalized day stage
    logic [EW-1:0] n_reg, n_next;
    logic [EW-1:0] doe6_reg;
    logic          era6_reg;
    // Year of era stage
    logic [YW-1:0] yoe_reg, yoe_next;
    logic [EW-1:0] doe7_reg;
    logic          era7_reg;
    // Day of year stage
    logic [DY-1:0] doy_reg, doy_next;
    logic [YW-1:0] yoe8_reg;
    logic          era8_reg;
    // Month index stage
    logic [3:0]    mp_reg, mp_next;
    logic [DY-1:0] doy9_reg;
    logic [YW-1:0] yoe9_reg;
    logic          era9_reg;
    // Output stage
    logic [11:0]   year_reg, year_next;
    logic [3:0]    month_reg, month_next;
    logic [4:0]    dom_reg, dom_next;

    logic [ZW-1:0] z, z_off;
    logic [PW-1:0] pa, pa_sh, py, py_sh;
    logic [EW-1:0] base, doy_full;
    logic [1:0]    c100;
    logic [DY-1:0] dom_full;
    logic [11:0]   era_years;

    // Split into era and day of era
    always_comb
    begin
        z         = ZW'(days) + ZW'(esc_pkg::DAYS_TO_EPOCH);
        era4_next = z >= ZW'(esc_pkg::ERA_SPLIT);
        z_off     = era4_next ? z - ZW'(esc_pkg::ERA_SPLIT)
                              : z - ZW'(esc_pkg::ERA_LO * esc_pkg::DAYS_PER_ERA);
        doe4_next = z_off[EW-1:0];
    end

    // Leap corrections: every fourth year, century, last day of era
    always_comb
    begin
        pa     = PW'(doe4_reg) * PW'(esc_pkg::DIV1460_MULT);
        pa_sh  = pa >> esc_pkg::DIV1460_SHIFT;
        a_next = pa_sh[6:0];
        b_next = 3'(doe4_reg >= EW'(esc_pkg::DAYS_PER_100Y))
               + 3'(doe4_reg >= EW'(2 * esc_pkg::DAYS_PER_100Y))
               + 3'(doe4_reg >= EW'(3 * esc_pkg::DAYS_PER_100Y))
               + 3'(doe4_reg >= EW'(4 * esc_pkg::DAYS_PER_100Y));
        c_next = doe4_reg == EW'(esc_pkg::DAYS_ERA_LAST);
    end

    assign n_next = doe5_reg - EW'(a_reg) + EW'(b_reg) - EW'(c_reg);

    always_comb
    begin
        py       = PW'(n_reg) * PW'(esc_pkg::DIV365_MULT);
        py_sh    = py >> esc_pkg::DIV365_SHIFT;
        yoe_next = py_sh[YW-1:0];
    end

    always_comb
    begin
        c100 = 2'(yoe_reg >= YW'(100)) + 2'(yoe_reg >= YW'(200)) + 2'(yoe_reg >= YW'(300));
        base = EW'(yoe_reg) * EW'(esc_pkg::DAYS_PER_YEAR) + EW'(yoe_reg >> 2) - EW'(c100);
        doy_full = doe7_reg - base;
        doy_next = doy_full[DY-1:0];
    end

    // Count month starts at or below the day of year
    always_comb
    begin
        mp_next = '0;
        for (int i = 1; i < 12; i++)
        begin
            if (doy_reg >= esc_pkg::month_start(4'(i)))
            begin
                mp_next = mp_next + 4'd1;
            end
        end
    end

    // March-based month back to January-based, carry into the year
    always_comb
    begin
        dom_full   = doy9_reg - esc_pkg::month_start(mp_reg) + DY'(1);
        dom_next   = dom_full[4:0];
        month_next = (mp_reg < 4'd10) ? mp_reg + 4'd3 : mp_reg - 4'd9;
        era_years  = era9_reg ? 12'((esc_pkg::ERA_LO + 1) * esc_pkg::YEARS_PER_ERA)
                              : 12'(esc_pkg::ERA_LO * esc_pkg::YEARS_PER_ERA);
        year_next  = 12'(yoe9_reg) + era_years + 12'(mp_reg >= 4'd10);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[esc_pkg::ST_DOE])
        begin
            doe4_reg <= doe4_next;
            era4_reg <= era4_next;
        end
        if (stage_en[esc_pkg::ST_CENT])
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            doe5_reg <= doe4_reg;
            era5_reg <= era4_reg;
        end
        if (stage_en[esc_pkg::ST_NORM])
        begin
            n_reg    <= n_next;
            doe6_reg <= doe5_reg;
            era6_reg <= era5_reg;
        end
        if (stage_en[esc_pkg::ST_YOE])
        begin
            yoe_reg  <= yoe_next;
            doe7_reg <= doe6_reg;
            era7_reg <= era6_reg;
        end
        if (stage_en[esc_pkg::ST_DOY])
        begin
            doy_reg  <= doy_next;
            yoe8_reg <= yoe_reg;
            era8_reg <= era7_reg;
        end
        if (stage_en[esc_pkg::ST_MP])
        begin
            mp_reg   <= mp_next;
            doy9_reg <= doy_reg;
            yoe9_reg <= yoe8_reg;
            era9_reg <= era8_reg;
        end
        if (stage_en[esc_pkg::ST_OUT])
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            dom_reg   <= dom_next;
        end
    end

    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = dom_reg;

endmodule

// File: rtl/esc_tod.sv
`timescale 1ns / 1ps

module esc_tod (
    input  logic                       clk,
    input  esc_pkg::stage_en_t         stage_en,
    input  logic [esc_pkg::REM_W-1:0]  rem,
    output logic [4:0]                 hour,
    output logic [5:0]                 minute
);

    localparam int MW = esc_pkg::MOD_W;

    logic [MW-1:0] mod_reg, mod_next, mod5_reg;
    logic [4:0]    hour5_reg, hour5_next;
    logic [4:0]    hour6_reg, hour7_reg, hour8_reg, hour9_reg, hour10_reg;
    logic [5:0]    min6_reg, min6_next, min7_reg, min8_reg, min9_reg, min10_reg;

    logic [14:0]   rq;
    logic [30:0]   pm, pm_sh;
    logic [8:0]    hq;
    logic [24:0]   ph, ph_sh;
    logic [MW-1:0] min_full;

    // Minute of day: rem / 60 = (rem / 4) / 15
    always_comb
    begin
        rq       = rem[esc_pkg::REM_W-1:2];
        pm       = 31'(rq) * 31'(esc_pkg::DIV15_MULT);
        pm_sh    = pm >> esc_pkg::DIV15_SHIFT;
        mod_next = pm_sh[MW-1:0];
    end

    always_comb
    begin
        hq         = mod_reg[MW-1:2];
        ph         = 25'(hq) * 25'(esc_pkg::DIV15_MULT);
        ph_sh      = ph >> esc_pkg::DIV15_SHIFT;
        hour5_next = ph_sh[4:0];
    end

    always_comb
    begin
        min_full  = mod5_reg - MW'(hour5_reg) * MW'(esc_pkg::MINS_PER_HOUR);
        min6_next = min_full[5:0];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[esc_pkg::ST_DOE])
        begin
            mod_reg <= mod_next;
        end
        if (stage_en[esc_pkg::ST_CENT])
        begin
            hour5_reg <= hour5_next;
            mod5_reg  <= mod_reg;
        end
        if (stage_en[esc_pkg::ST_NORM])
        begin
            hour6_reg <= hour5_reg;
            min6_reg  <= min6_next;
        end
        if (stage_en[esc_pkg::ST_YOE])
        begin
            hour7_reg <= hour6_reg;
            min7_reg  <= min6_reg;
        end
        if (stage_en[esc_pkg::ST_DOY])
        begin
            hour8_reg <= hour7_reg;
            min8_reg  <= min7_reg;
        end
        if (stage_en[esc_pkg::ST_MP])
        begin
            hour9_reg <= hour8_reg;
            min9_reg  <= min8_reg;
        end
        if (stage_en[esc_pkg::ST_OUT])
        begin
            hour10_reg <= hour9_reg;
            min10_reg  <= min9_reg;
        end
    end

    assign hour   = hour10_reg;
    assign minute = min10_reg;

endmodule

// File: test/epoch_seconds_to_calendar_unit_tb.sv
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_unit_tb;

    // Run ends here no matter what; the slowest correct run is far below this.
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PIPE_LATENCY  = 11;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 190;

    // One calendar result, laid out as the result ports are.
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } cal_t;

    // One row of the directed table: the zone offset in force, the item,
    // and, where it is obvious, the result written out by hand.
    typedef struct {
        logic signed [4:0] offs;
        logic [31:0]       secs;
        bit                typed;
        cal_t              want;
    } date_vec_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic signed [4:0] zone_offset_hours;
    logic              item_valid;
    logic              item_stall;
    logic [31:0]       epoch_seconds;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [11:0]       year;
    logic [3:0]        month;
    logic [4:0]        day_of_month;
    logic [4:0]        hour;
    logic [5:0]        minute;

    // Testbench copy of the zone offset register.
    logic signed [4:0] cur_offs = esc_pkg::ZONE_OFFSET_RESET;

    cal_t      pending_dates[$];
    date_vec_t date_vecs[$];

    int  mismatches = 0;
    int  results_seen = 0;
    int  cycles = 0;
    int  gap_pct = 0;
    int  stall_pct = 0;
    int  stall_left = 0;
    bit  calm = 0;
    bit  valid_hi = 0;

    epoch_seconds_to_calendar_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .zone_offset_hours (zone_offset_hours),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .epoch_seconds     (epoch_seconds),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .year              (year),
        .month             (month),
        .day_of_month      (day_of_month),
        .hour              (hour),
        .minute            (minute)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Local calendar date for a UTC second count under a given zone offset.
    // Days are counted from 0000-03-01 so the leap day is the last day of a year.
    function automatic cal_t to_local_calendar(input logic [31:0] secs,
                                               input logic signed [4:0] offs);
        longint t;
        longint days;
        longint rem;
        longint z;
        longint era;
        longint doe;
        longint yoe;
        longint doy;
        longint mp;
        longint mon;
        cal_t   r;
        t = longint'(secs) + longint'(offs) * esc_pkg::SECS_PER_HOUR;
        if (t < 0)
            t = 0;
        days = t / esc_pkg::SECS_PER_DAY;
        rem  = t % esc_pkg::SECS_PER_DAY;
        z    = days + esc_pkg::DAYS_TO_EPOCH;
        era  = z / esc_pkg::DAYS_PER_ERA;
        doe  = z - era * esc_pkg::DAYS_PER_ERA;
        yoe  = (doe - doe / esc_pkg::DAYS_PER_4Y + doe / esc_pkg::DAYS_PER_100Y
                - doe / esc_pkg::DAYS_ERA_LAST) / esc_pkg::DAYS_PER_YEAR;
        doy  = doe - (esc_pkg::DAYS_PER_YEAR * yoe + yoe / 4 - yoe / 100);
        mp   = (5 * doy + 2) / 153;
        mon  = (mp < 10) ? mp + 3 : mp - 9;
        r.day_of_month = 5'(doy - (153 * mp + 2) / 5 + 1);
        r.month        = 4'(mon);
        r.year         = 12'(yoe + era * esc_pkg::YEARS_PER_ERA + ((mon <= 2) ? 1 : 0));
        r.hour         = 5'(rem / esc_pkg::SECS_PER_HOUR);
        r.minute       = 6'((rem % esc_pkg::SECS_PER_HOUR) / esc_pkg::SECS_PER_MIN);
        return r;
    endfunction

    function automatic bit is_leap(input int yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    // Seconds from the epoch to midnight UTC of January 1st of a year.
    function automatic longint year_start_secs(input int yr);
        longint days;
        days = 0;
        for (int y = esc_pkg::EPOCH_YEAR; y < yr; y++)
            days += is_leap(y) ? 366 : 365;
        return days * esc_pkg::SECS_PER_DAY;
    endfunction

    // Random item, weighted toward the edges of days, years, February and the
    // ends of the input range.
    function automatic logic [31:0] pick_secs();
        longint v;
        int     yr;
        case ($urandom_range(5))
            0: v = $urandom();
            1: v = $urandom_range(200000);
            2: v = 64'hFFFF_FFFF - $urandom_range(200000);
            3: v = longint'($urandom_range(49709, 1)) * esc_pkg::SECS_PER_DAY - 60
                   + $urandom_range(120);
            4:
            begin
                yr = $urandom_range(2106, 1971);
                v  = year_start_secs(yr) - 72000 + $urandom_range(144000);
            end
            default:
            begin
                yr = $urandom_range(2105, 1970);
                v  = year_start_secs(yr) + 59 * esc_pkg::SECS_PER_DAY - 129600
                     + $urandom_range(259200);
            end
        endcase
        if (v < 0)
            v = 0;
        if (v > 64'hFFFF_FFFF)
            v = 64'hFFFF_FFFF;
        return 32'(v);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic compare_date(input cal_t got, input cal_t want);
        if (got.year !== want.year)
            report_mismatch($sformatf("result %0d year %0d, expected %0d",
                                      results_seen, got.year, want.year));
        if (got.month !== want.month)
            report_mismatch($sformatf("result %0d month %0d, expected %0d",
                                      results_seen, got.month, want.month));
        if (got.day_of_month !== want.day_of_month)
            report_mismatch($sformatf("result %0d day %0d, expected %0d",
                                      results_seen, got.day_of_month, want.day_of_month));
        if (got.hour !== want.hour)
            report_mismatch($sformatf("result %0d hour %0d, expected %0d",
                                      results_seen, got.hour, want.hour));
        if (got.minute !== want.minute)
            report_mismatch($sformatf("result %0d minute %0d, expected %0d",
                                      results_seen, got.minute, want.minute));
    endtask

    task automatic add_vec(input logic signed [4:0] offs, input logic [31:0] secs,
                           input bit typed, input int yr, input int mo, input int dd,
                           input int hh, input int mm);
        date_vec_t v;
        v.offs  = offs;
        v.secs  = secs;
        v.typed = typed;
        v.want  = cal_t'{12'(yr), 4'(mo), 5'(dd), 5'(hh), 6'(mm)};
        date_vecs.push_back(v);
    endtask

    // Drop valid, but only once per step: a later raise must not share the step.
    task automatic lower_valid();
        if (valid_hi)
        begin
            item_valid <= 1'b0;
            valid_hi = 0;
        end
    endtask

    // Idle the input side for a burst; drive noise on the payload meanwhile.
    task automatic idle_input(input int n);
        lower_valid();
        epoch_seconds <= $urandom();
        repeat (n) @(posedge clk);
    endtask

    // Hold the input side until every expected result has come back.
    task automatic drain_pipeline();
        lower_valid();
        while (pending_dates.size() != 0)
            @(posedge clk);
    endtask

    // Write the zone offset; call only with nothing in flight.
    task automatic write_zone(input logic signed [4:0] offs);
        cfg_valid         <= 1'b1;
        zone_offset_hours <= offs;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_offs = offs;
    endtask

    // Offer one item and hold it until the block takes it; record the
    // expected date at the accepting edge.
    task automatic send_item(input logic [31:0] secs, input bit typed, input cal_t want);
        item_valid    <= 1'b1;
        epoch_seconds <= secs;
        valid_hi = 1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_dates.push_back(typed ? want : to_local_calendar(secs, cur_offs));
    endtask

    task automatic maybe_gap();
        if (!calm && $urandom_range(99) < gap_pct)
            idle_input($urandom_range(13, 1));
    endtask

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: check each accepted result against the oldest expectation,
    // then pick the stall for the next cycle. Values read here are the ones
    // that stood before this edge.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_dates.size() == 0)
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
            else
                compare_date(cal_t'{year, month, day_of_month, hour, minute},
                             pending_dates.pop_front());
            results_seen++;
        end
        if (calm)
            stall_left = 0;
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else if (!calm && $urandom_range(99) < stall_pct)
        begin
            stall_left = $urandom_range(13, 1) - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // Input side: reset, directed table, random phases, then the end check.
    initial
    begin
        cal_t none;
        none = '0;

        rst_n             <= 1'b0;
        cfg_valid         <= 1'b0;
        zone_offset_hours <= '0;
        item_valid        <= 1'b0;
        epoch_seconds     <= '0;

        // Rows under the reset offset come first so the reset value is seen.
        add_vec(8, 32'd0, 1, 1970, 1, 1, 8, 0);
        add_vec(8, 32'hFFFF_FFFF, 1, 2106, 2, 7, 14, 28);
        add_vec(0, 32'd0, 1, 1970, 1, 1, 0, 0);
        add_vec(0, 32'hFFFF_FFFF, 1, 2106, 2, 7, 6, 28);
        add_vec(0, 32'd59, 0, 0, 0, 0, 0, 0);
        // Leap days: a plain leap year, the 400-year case, and the century
        // that is not a leap year, then mid-range and alternating bit patterns.
        add_vec(0, 32'd68169600, 0, 0, 0, 0, 0, 0);
        add_vec(0, 32'd951782400, 0, 0, 0, 0, 0, 0);
        add_vec(0, 32'd951868800, 0, 0, 0, 0, 0, 0);
        add_vec(0, 32'd4107542340, 0, 0, 0, 0, 0, 0);
        add_vec(0, 32'd4107542400, 0, 0, 0, 0, 0, 0);
        add_vec(0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
        add_vec(0, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
        add_vec(0, 32'hAAAA_AAAA, 0, 0, 0, 0, 0, 0);
        add_vec(0, 32'h5555_5555, 0, 0, 0, 0, 0, 0);
        // Local time before the epoch clamps to midnight, 1970-01-01.
        add_vec(-12, 32'd0, 1, 1970, 1, 1, 0, 0);
        add_vec(-12, 32'd43199, 1, 1970, 1, 1, 0, 0);
        add_vec(-12, 32'd43200, 1, 1970, 1, 1, 0, 0);
        add_vec(-12, 32'hFFFF_FFFF, 1, 2106, 2, 6, 18, 28);
        // Offset carries into the next year.
        add_vec(14, 32'd946634400, 0, 0, 0, 0, 0, 0);
        add_vec(14, 32'hFFFF_FFFF, 1, 2106, 2, 7, 20, 28);
        // Offsets outside the usual zone range apply as they stand.
        add_vec(-16, 32'd0, 1, 1970, 1, 1, 0, 0);
        add_vec(-16, 32'd57600, 1, 1970, 1, 1, 0, 0);
        add_vec(-16, 32'd86400, 0, 0, 0, 0, 0, 0);
        add_vec(15, 32'd0, 1, 1970, 1, 1, 15, 0);
        add_vec(15, 32'hFFFF_FFFF, 1, 2106, 2, 7, 21, 28);
        add_vec(1, 32'd946681200, 0, 0, 0, 0, 0, 0);
        add_vec(-1, 32'd86400, 0, 0, 0, 0, 0, 0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 20;
        stall_pct = 20;
        foreach (date_vecs[i])
        begin
            if (date_vecs[i].offs != cur_offs)
            begin
                drain_pipeline();
                write_zone(date_vecs[i].offs);
            end
            maybe_gap();
            send_item(date_vecs[i].secs, date_vecs[i].typed, date_vecs[i].want);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            logic signed [4:0] offs;
            case (p)
                0: offs = -12;
                1: offs = 14;
                2: offs = -16;
                3: offs = 15;
                4: offs = 0;
                5: offs = esc_pkg::ZONE_OFFSET_RESET;
                default: offs = 5'($urandom_range(31));
            endcase
            // Cycle through no idling, light idling and heavy idling; the
            // last phase runs flat out.
            case (p % 3)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 15; stall_pct = 15; end
                default: begin gap_pct = 40; stall_pct = 40; end
            endcase
            drain_pipeline();
            calm = (p == RANDOM_PHASES - 1);
            write_zone(offs);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (!calm && $urandom_range(149) == 0)
                    drain_pipeline();
                maybe_gap();
                send_item(pick_secs(), 0, none);
            end
        end

        // Wait out everything in flight, then a while longer to catch strays.
        drain_pipeline();
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (mismatches == 0 && pending_dates.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
